@@ sv/sep_pkg.sv @@
// ----------------------------------------------------------------------------
// sep_pkg: shared types and constants
// Fixed-point formats, polynomial and reciprocal tables, register indexes.
// ----------------------------------------------------------------------------
package sep_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int Q30_FRAC      = 30;
  localparam int LOG_FRAC_BITS = 24;
  localparam int LG_W          = 29;   // (30 << 24) fits in 29 bits
  localparam int HORNER_TERMS  = 10;
  localparam int RECIP_SHIFT   = 34;
  localparam int SINE_STAGES   = 7;
  localparam int LOG_STEPS     = LOG_FRAC_BITS + 3;
  localparam int EXP_STEPS     = 3 * HORNER_TERMS + 3;

  typedef logic [Q30_FRAC:0] q30_t;    // 0 .. 2^31 - 1 (unsigned, 30 fractional bits)

  typedef struct packed {
    logic neg;
    logic zero;
  } side_t;

  localparam q30_t Q30_ONE = 31'd1073741824;

  // odd sine polynomial, Q30
  localparam q30_t SC1  = 31'd1686629773;
  localparam q30_t SC3  = 31'd693598668;
  localparam q30_t SC5  = 31'd85569306;
  localparam q30_t SC7  = 31'd5026995;
  localparam q30_t SC9  = 31'd172272;
  localparam q30_t SC11 = 31'd3864;
  localparam q30_t SINE_C [5] = '{SC9, SC7, SC5, SC3, SC1};

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // floor((2^34 - 1) / k) for k = 1 .. 10
  localparam logic [RECIP_SHIFT-1:0] RECIP_TAB [HORNER_TERMS] = '{
    34'd17179869183, 34'd8589934591, 34'd5726623061, 34'd4294967295,
    34'd3435973836,  34'd2863311530, 34'd2454267026, 34'd2147483647,
    34'd1908874353,  34'd1717986918
  };

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_X    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_Y    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_EXPONENT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP     = 8'd3;

endpackage

@@ sv/sep_sine.sv @@
// ----------------------------------------------------------------------------
// sep_sine: quarter-wave sine pipeline
// Evaluates S(r) and S(1 - r) in Q30, one multiply per stage.
// ----------------------------------------------------------------------------
module sep_sine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [1:0]                     in_quad,
  input  logic [sep_pkg::Q30_FRAC-1:0]   in_r,
  output logic                           out_valid,
  output logic [1:0]                     out_quad,
  output sep_pkg::q30_t                  out_sa,
  output sep_pkg::q30_t                  out_sb
);
  import sep_pkg::*;

  localparam int NS = SINE_STAGES;

  logic [NS:1] vld_r, vld_nxt;
  logic [1:0]  quad_r  [NS:1];
  logic [1:0]  quad_nxt[NS:1];
  q30_t        x_r   [NS:1][2];
  q30_t        x_nxt [NS:1][2];
  q30_t        x2_r  [NS:1][2];
  q30_t        x2_nxt[NS:1][2];
  q30_t        t_r   [NS:1][2];
  q30_t        t_nxt [NS:1][2];
  q30_t        x_in  [2];
  logic [61:0] sq_c  [2];
  logic [61:0] prod_c[NS:2][2];
  logic [31:0] fin_c [2];

  always_comb begin
    x_in[0] = {1'b0, in_r};
    x_in[1] = Q30_ONE - {1'b0, in_r};
    vld_nxt = {vld_r[NS-1:1], in_valid};
    quad_nxt[1] = in_quad;
    for (int s = 2; s <= NS; s++) begin
      quad_nxt[s] = quad_r[s-1];
    end
    for (int l = 0; l < 2; l++) begin
      sq_c[l]      = x_in[l] * x_in[l];
      x_nxt[1][l]  = x_in[l];
      x2_nxt[1][l] = sq_c[l][60:30];
      t_nxt[1][l]  = SC11;
      for (int s = 2; s < NS; s++) begin
        prod_c[s][l] = x2_r[s-1][l] * t_r[s-1][l];
        t_nxt[s][l]  = SINE_C[s-2] - prod_c[s][l][60:30];
        x_nxt[s][l]  = x_r[s-1][l];
        x2_nxt[s][l] = x2_r[s-1][l];
      end
      // last stage: x * t, clamped to one
      prod_c[NS][l] = x_r[NS-1][l] * t_r[NS-1][l];
      fin_c[l]      = prod_c[NS][l][61:30];
      t_nxt[NS][l]  = (fin_c[l] > {1'b0, Q30_ONE}) ? Q30_ONE : fin_c[l][30:0];
      x_nxt[NS][l]  = x_r[NS-1][l];
      x2_nxt[NS][l] = x2_r[NS-1][l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quad_r <= quad_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    t_r    <= t_nxt;
  end

  assign out_valid = vld_r[NS];
  assign out_quad  = quad_r[NS];
  assign out_sa    = t_r[NS][0];
  assign out_sb    = t_r[NS][1];

endmodule

@@ sv/sep_log.sv @@
// ----------------------------------------------------------------------------
// sep_log: -log2 of a Q30 magnitude
// Leading-one search, normalise, then one squaring per stage for 24 bits.
// ----------------------------------------------------------------------------
module sep_log (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  sep_pkg::q30_t               in_m,
  input  sep_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [sep_pkg::LG_W-1:0]    out_lg,
  output sep_pkg::side_t              out_side
);
  import sep_pkg::*;

  localparam int NL = LOG_STEPS;       // steps 0 .. NL-1
  localparam int FB = LOG_FRAC_BITS;

  logic [NL-1:0]   vld_r, vld_nxt;
  side_t           side_r  [NL];
  side_t           side_nxt[NL];
  logic [4:0]      k_r     [NL-1];
  logic [4:0]      k_nxt   [NL-1];
  q30_t            m_r, m_nxt;
  q30_t            f_r     [FB+1:1];
  q30_t            f_nxt   [FB+1:1];
  logic [FB-1:0]   frac_r  [FB+1:1];
  logic [FB-1:0]   frac_nxt[FB+1:1];
  logic [LG_W-1:0] lg_r, lg_nxt;
  logic [61:0]     sq_c    [FB+1:2];
  logic [31:0]     v_c     [FB+1:2];
  logic [4:0]      lead_c;

  always_comb begin
    lead_c = '0;
    for (int i = 0; i <= Q30_FRAC; i++) begin
      if (in_m[i]) begin
        lead_c = 5'(i);
      end
    end
    vld_nxt     = {vld_r[NL-2:0], in_valid};
    side_nxt[0] = in_side;
    for (int s = 1; s < NL; s++) begin
      side_nxt[s] = side_r[s-1];
    end
    m_nxt    = in_m;
    k_nxt[0] = lead_c;
    for (int s = 1; s < NL - 1; s++) begin
      k_nxt[s] = k_r[s-1];
    end
    f_nxt[1]    = m_r << (5'd30 - k_r[0]);
    frac_nxt[1] = '0;
    for (int s = 2; s <= FB + 1; s++) begin
      sq_c[s] = f_r[s-1] * f_r[s-1];
      v_c[s]  = sq_c[s][61:30];
      if (v_c[s][31]) begin
        f_nxt[s]    = v_c[s][31:1];
        frac_nxt[s] = {frac_r[s-1][FB-2:0], 1'b1};
      end else begin
        f_nxt[s]    = v_c[s][30:0];
        frac_nxt[s] = {frac_r[s-1][FB-2:0], 1'b0};
      end
    end
    lg_nxt = {5'd30 - k_r[NL-2], {FB{1'b0}}} - {5'd0, frac_r[FB+1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    k_r    <= k_nxt;
    m_r    <= m_nxt;
    f_r    <= f_nxt;
    frac_r <= frac_nxt;
    lg_r   <= lg_nxt;
  end

  assign out_valid = vld_r[NL-1];
  assign out_side  = side_r[NL-1];
  assign out_lg    = lg_r;

endmodule

@@ sv/sep_exp.sv @@
// ----------------------------------------------------------------------------
// sep_exp: 2^-(lg * e) in Q30
// Scale by exponent, e^-t by a ten-term Horner chain, then integer shift.
// ----------------------------------------------------------------------------
module sep_exp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [sep_pkg::LG_W-1:0]    in_lg,
  input  sep_pkg::side_t              in_side,
  input  logic [15:0]                 in_e,
  output logic                        out_valid,
  output sep_pkg::q30_t               out_pw,
  output sep_pkg::side_t              out_side
);
  import sep_pkg::*;

  localparam int NE = EXP_STEPS;

  typedef struct packed {
    side_t      side;
    logic       under;
    logic [4:0] n;
  } etag_t;

  logic [NE-1:0] vld_r, vld_nxt;
  etag_t         tag_r  [NE];
  etag_t         tag_nxt[NE];
  logic [44:0]   p_c;
  logic [29:0]   gs_r;
  logic [59:0]   ln_c;
  logic [29:0]   t1_r;
  logic [29:0]   t_chain[HORNER_TERMS+1];
  q30_t          h_chain[HORNER_TERMS+1];
  q30_t          pw_r, pw_nxt;

  always_comb begin
    p_c  = in_lg * in_e;
    ln_c = gs_r * LN2_Q30;
    vld_nxt = {vld_r[NE-2:0], in_valid};
    tag_nxt[0].side  = in_side;
    tag_nxt[0].under = (p_c[44:36] >= 9'd31);
    tag_nxt[0].n     = p_c[40:36];
    for (int s = 1; s < NE; s++) begin
      tag_nxt[s] = tag_r[s-1];
    end
    if (tag_r[NE-2].side.zero) begin
      pw_nxt = (in_e == '0) ? Q30_ONE : '0;
    end else if (tag_r[NE-2].under) begin
      pw_nxt = '0;
    end else begin
      pw_nxt = h_chain[HORNER_TERMS] >> tag_r[NE-2].n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    gs_r  <= p_c[35:6];
    t1_r  <= ln_c[59:30];
    pw_r  <= pw_nxt;
  end

  assign t_chain[0] = t1_r;
  assign h_chain[0] = Q30_ONE;

  // h = 1 - (t*h)/k, k from ten down to one; each term: multiply,
  // reciprocal multiply, remainder correction
  for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_term
    localparam int          K   = HORNER_TERMS - j;
    localparam logic [3:0]  K_W = 4'(K);

    logic [29:0] ta_r, tb_r, tc_r;
    q30_t        qa_r, qb_r, q0b_r, hc_r;
    logic [60:0] prod_a;
    logic [64:0] prod_b;
    logic [34:0] kq_c;
    logic [34:0] rem_c;
    q30_t        q_c;

    always_comb begin
      prod_a = t_chain[j] * h_chain[j];
      prod_b = qa_r * RECIP_TAB[K-1];
      kq_c   = q0b_r * K_W;
      rem_c  = {4'd0, qb_r} - kq_c;
      q_c    = (rem_c >= 35'(K)) ? q0b_r + 31'd1 : q0b_r;
    end

    always_ff @(posedge clk) begin
      ta_r  <= t_chain[j];
      qa_r  <= prod_a[60:30];
      tb_r  <= ta_r;
      qb_r  <= qa_r;
      q0b_r <= prod_b[64:34];
      tc_r  <= tb_r;
      hc_r  <= Q30_ONE - q_c;
    end

    assign t_chain[j+1] = tc_r;
    assign h_chain[j+1] = hc_r;
  end

  assign out_valid = vld_r[NE-1];
  assign out_side  = tag_r[NE-1].side;
  assign out_pw    = pw_r;

endmodule

@@ sv/superellipse_point_generator.sv @@
// ----------------------------------------------------------------------------
// superellipse_point_generator: superellipse sampling, one point per item
// Pipeline: 71 register stages from the accepting edge to out_valid.
// Throughput: one item per cycle, fully pipelined; busy is never raised.
// The receiver cannot stall, so results stream out at the input rate.
// Reset (rst_n low, synchronous) empties the pipeline and reloads the
// registers: axes 1.0, exponent 1.0, angle step 1024.
// ----------------------------------------------------------------------------
module superellipse_point_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  // item input
  input  logic                               start,
  output logic                               busy,
  input  logic [15:0]                        in_sample_index,
  // result output
  output logic                               out_valid,
  output logic signed [16:0]                 out_point_x,
  output logic signed [16:0]                 out_point_y,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_data
);
  import sep_pkg::*;

  // Stage map (register stages):
  //   1   phase = index * step + half turn, split into quadrant and Q30 r
  //   7   quarter sine of r and of (1 - r)
  //   1   quadrant select, signs, zero flags
  //   27  -log2 per coordinate (leading one, normalise, 24 squarings)
  //   33  exponent scale, e^-t Horner chain, integer shift
  //   1   axis multiply
  //   1   round, sign, output register

  logic [15:0] axis_x_r, axis_y_r, shape_e_r, step_r;

  logic        in_accept;
  logic [31:0] phase_prod_c;
  logic [ANGLE_BITS-1:0] phase_c;
  logic        ph_vld_r;
  logic [1:0]  ph_quad_r;
  logic [Q30_FRAC-1:0] ph_r_r;

  logic        sn_vld;
  logic [1:0]  sn_quad;
  q30_t        sn_sa, sn_sb;

  logic        sel_vld_r;
  q30_t        cm_r, sm_r, cm_nxt, sm_nxt;
  side_t       cside_r, sside_r, cside_nxt, sside_nxt;

  logic        lx_vld, ly_vld;
  logic [LG_W-1:0] lx_lg, ly_lg;
  side_t       lx_side, ly_side;

  logic        ex_vld, ey_vld;
  q30_t        ex_pw, ey_pw;
  side_t       ex_side, ey_side;

  logic        mul_vld_r;
  logic        negx_r, negy_r;
  logic [46:0] mulx_r, muly_r;
  logic [47:0] rndx_c, rndy_c;
  logic [16:0] magx_c, magy_c;

  logic        out_vld_r;
  logic [16:0] outx_r, outy_r;

  // never holds off: a new item may enter every cycle
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start & ~busy;

  // register file; the user must write only while the pipeline is empty, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r  <= 16'd256;
      axis_y_r  <= 16'd256;
      shape_e_r <= 16'd4096;
      step_r    <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEMI_AXIS_X:    axis_x_r  <= cfg_data;
        REG_SEMI_AXIS_Y:    axis_y_r  <= cfg_data;
        REG_SHAPE_EXPONENT: shape_e_r <= cfg_data;
        REG_ANGLE_STEP:     step_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase in turns; adding half a turn puts index 0 at minus half a turn
  always_comb begin
    phase_prod_c = in_sample_index * step_r;
    phase_c = phase_prod_c[ANGLE_BITS-1:0] + {1'b1, {(ANGLE_BITS-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_vld_r <= 1'b0;
    end else begin
      ph_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    ph_quad_r <= phase_c[ANGLE_BITS-1 -: 2];
    ph_r_r    <= {phase_c[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
  end

  sep_sine u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ph_vld_r),
    .in_quad   (ph_quad_r),
    .in_r      (ph_r_r),
    .out_valid (sn_vld),
    .out_quad  (sn_quad),
    .out_sa    (sn_sa),
    .out_sb    (sn_sb)
  );

  // quadrant folding; an exact zero counts as positive
  always_comb begin
    sm_nxt = sn_sa;
    cm_nxt = sn_sb;
    cside_nxt.neg = 1'b0;
    sside_nxt.neg = 1'b0;
    case (sn_quad)
      2'd0: begin
        sm_nxt = sn_sa; cm_nxt = sn_sb;
      end
      2'd1: begin
        sm_nxt = sn_sb; cm_nxt = sn_sa; cside_nxt.neg = 1'b1;
      end
      2'd2: begin
        sm_nxt = sn_sa; cm_nxt = sn_sb;
        cside_nxt.neg = 1'b1; sside_nxt.neg = 1'b1;
      end
      default: begin
        sm_nxt = sn_sb; cm_nxt = sn_sa; sside_nxt.neg = 1'b1;
      end
    endcase
    cside_nxt.zero = (cm_nxt == '0);
    sside_nxt.zero = (sm_nxt == '0);
    if (cside_nxt.zero) begin
      cside_nxt.neg = 1'b0;
    end
    if (sside_nxt.zero) begin
      sside_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else begin
      sel_vld_r <= sn_vld;
    end
  end

  always_ff @(posedge clk) begin
    cm_r    <= cm_nxt;
    sm_r    <= sm_nxt;
    cside_r <= cside_nxt;
    sside_r <= sside_nxt;
  end

  sep_log u_log_x (
    .clk (clk), .rst_n (rst_n),
    .in_valid (sel_vld_r), .in_m (cm_r), .in_side (cside_r),
    .out_valid (lx_vld), .out_lg (lx_lg), .out_side (lx_side)
  );

  sep_log u_log_y (
    .clk (clk), .rst_n (rst_n),
    .in_valid (sel_vld_r), .in_m (sm_r), .in_side (sside_r),
    .out_valid (ly_vld), .out_lg (ly_lg), .out_side (ly_side)
  );

  sep_exp u_exp_x (
    .clk (clk), .rst_n (rst_n),
    .in_valid (lx_vld), .in_lg (lx_lg), .in_side (lx_side), .in_e (shape_e_r),
    .out_valid (ex_vld), .out_pw (ex_pw), .out_side (ex_side)
  );

  sep_exp u_exp_y (
    .clk (clk), .rst_n (rst_n),
    .in_valid (ly_vld), .in_lg (ly_lg), .in_side (ly_side), .in_e (shape_e_r),
    .out_valid (ey_vld), .out_pw (ey_pw), .out_side (ey_side)
  );

  // axis scaling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= ex_vld & ey_vld;
    end
  end

  always_ff @(posedge clk) begin
    mulx_r <= axis_x_r * ex_pw;
    muly_r <= axis_y_r * ey_pw;
    negx_r <= ex_side.neg;
    negy_r <= ey_side.neg;
  end

  // round to Q8.8, magnitude never exceeds the axis
  always_comb begin
    rndx_c = {1'b0, mulx_r} + 48'd536870912;
    rndy_c = {1'b0, muly_r} + 48'd536870912;
    magx_c = rndx_c[46:30];
    magy_c = rndy_c[46:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    outx_r <= negx_r ? (17'd0 - magx_c) : magx_c;
    outy_r <= negy_r ? (17'd0 - magy_c) : magy_c;
  end

  assign out_valid   = out_vld_r;
  assign out_point_x = signed'(outx_r);
  assign out_point_y = signed'(outy_r);

endmodule

@@ verif/superellipse_point_generator_tb.sv @@
// ----------------------------------------------------------------------------
// superellipse_point_generator_tb: self-checking bench for the point generator
// Drives sample indexes through the command port and rewrites the registers
// between phases. A bit-exact predictor in the bench forms each expected
// point, and every strobed result is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module superellipse_point_generator_tb;
  import sep_pkg::*;

  localparam int          HALF_PERIOD = 4;
  localparam int          PIPE_DEPTH  = 70;     // accepting edge to strobe
  localparam int          IDLE_LIMIT  = 1000;   // cycles with no handshake or strobe at all
  localparam int          RAND_ITEMS  = 530;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_sample_index = '0;
  logic out_valid;
  logic signed [16:0] out_point_x;
  logic signed [16:0] out_point_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // bench copy of the registers, reset values
  logic [15:0] axis_x_q = 16'd256;
  logic [15:0] axis_y_q = 16'd256;
  logic [15:0] exponent_q = 16'd4096;
  logic [15:0] step_q = 16'd1024;

  point_t pending_points[$];
  int     mismatches = 0;
  int     idle_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  superellipse_point_generator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_index (in_sample_index),
    .out_valid       (out_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // sin(pi/2 * x) for x in Q30 [0, 1], odd polynomial, products truncated
  function automatic logic [63:0] quarter_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] acc;
    x2  = (x * x) >> 30;
    acc = 64'(SC9) - ((x2 * 64'(SC11)) >> 30);
    acc = 64'(SC7) - ((x2 * acc) >> 30);
    acc = 64'(SC5) - ((x2 * acc) >> 30);
    acc = 64'(SC3) - ((x2 * acc) >> 30);
    acc = 64'(SC1) - ((x2 * acc) >> 30);
    acc = (x * acc) >> 30;
    if (acc > ONE_Q30) acc = ONE_Q30;
    return acc;
  endfunction

  // m^e, m in Q30, e in Q4.12; via -log2 by squaring and a Horner exp
  function automatic logic [63:0] magnitude_power(input logic [63:0] m,
                                                  input logic [63:0] e);
    int          lead;
    logic [63:0] f, frac, lg, prod, g, t, h, n;
    lead = 0;
    frac = '0;
    if (m == 0) return (e == 0) ? ONE_Q30 : 64'd0;
    while (lead < 30 && (m >> (lead + 1)) != 0) lead++;
    f = m << (30 - lead);
    for (int i = 0; i < LOG_FRAC_BITS; i++) begin
      f = (f * f) >> 30;
      frac = frac << 1;
      if (f >= (ONE_Q30 << 1)) begin
        f = f >> 1;
        frac = frac | 64'd1;
      end
    end
    lg   = (64'(30 - lead) << LOG_FRAC_BITS) - frac;
    prod = lg * e;
    n    = prod >> 36;
    if (n >= 31) return 64'd0;
    g = prod & ((64'd1 << 36) - 1);
    t = ((g >> 6) * 64'(LN2_Q30)) >> 30;
    h = ONE_Q30;
    for (int k = 10; k >= 1; k--) h = ONE_Q30 - ((t * h) >> 30) / 64'(k);
    return h >> n;
  endfunction

  function automatic logic signed [16:0] scaled_coord(input logic [15:0] axis,
                                                      input logic [63:0] mag,
                                                      input logic neg);
    logic [63:0] v;
    v = (64'(axis) * magnitude_power(mag, 64'(exponent_q)) + (ONE_Q30 >> 1)) >> 30;
    if (neg) v = 64'd0 - v;
    return v[16:0];
  endfunction

  function automatic point_t curve_point(input logic [15:0] idx);
    logic [15:0] phase;
    logic [31:0] turn;
    logic [63:0] r, sa, sb, cm, sm;
    logic        cneg, sneg;
    point_t      p;
    // the half-turn offset puts index 0 at minus half a turn
    phase = 16'(32'(idx) * 32'(step_q) + 32'd32768);
    turn  = {phase, 16'd0};
    r     = 64'(turn[29:0]);
    sa    = quarter_sin(r);
    sb    = quarter_sin(ONE_Q30 - r);
    case (turn[31:30])
      2'd0: begin sm = sa; cm = sb; sneg = 1'b0; cneg = 1'b0; end
      2'd1: begin sm = sb; cm = sa; sneg = 1'b0; cneg = 1'b1; end
      2'd2: begin sm = sa; cm = sb; sneg = 1'b1; cneg = 1'b1; end
      default: begin sm = sb; cm = sa; sneg = 1'b1; cneg = 1'b0; end
    endcase
    // an exact zero counts as non-negative
    if (cm == 0) cneg = 1'b0;
    if (sm == 0) sneg = 1'b0;
    p.x = scaled_coord(axis_x_q, cm, cneg);
    p.y = scaled_coord(axis_y_q, sm, sneg);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Checking: results cannot be held off, so every strobe is taken
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point", 1, 0);
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x) report_mismatch("point_x", out_point_x, want.x);
        if (out_point_y !== want.y) report_mismatch("point_y", out_point_y, want.y);
      end
    end
  end

  // watchdog: any handshake or strobe resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no activity for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // start stays high on return, so back-to-back items need no re-raise
  task automatic send_item(input logic [15:0] idx);
    point_t expected;
    start <= 1'b1;
    in_sample_index <= idx;
    do @(posedge clk); while (busy);
    expected = curve_point(idx);
    pending_points.insert(pending_points.size(), expected);
  endtask

  // mostly no gap, some short, a few long
  task automatic sender_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap  = (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 4) : $urandom_range(15, 60);
    if (gap > 0) begin
      start <= 1'b0;
      in_sample_index <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // only called with the pipeline drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEMI_AXIS_X:    axis_x_q = value;
      REG_SEMI_AXIS_Y:    axis_y_q = value;
      REG_SHAPE_EXPONENT: exponent_q = value;
      REG_ANGLE_STEP:     step_q = value;
      default: ;          // unknown index: dropped
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [15:0] ax, input logic [15:0] ay,
                           input logic [15:0] ex, input logic [15:0] st);
    drain();
    write_reg(REG_SEMI_AXIS_X, ax);
    write_reg(REG_SEMI_AXIS_Y, ay);
    write_reg(REG_SHAPE_EXPONENT, ex);
    write_reg(REG_ANGLE_STEP, st);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset values: unit circle, 64 points per turn; quarter turns land on zeros
  task automatic test_reset_circle();
    for (int i = 0; i < 64; i += 8) send_item(16'(i));
    send_item(16'hFFFF);
  endtask

  // full-scale axes, both exponent extremes, zero magnitudes at quarter turns
  task automatic test_extremes();
    set_shape(16'hFFFF, 16'hFFFF, 16'd0, 16'd16384);
    for (int i = 0; i < 4; i++) send_item(16'(i));
    drain();
    write_reg(REG_SHAPE_EXPONENT, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_item(16'(i));
    send_item(16'd16385);
  endtask

  // zero axes and zero step; step 1 with index wrap
  task automatic test_degenerate();
    set_shape(16'd0, 16'd0, 16'd2048, 16'd0);
    send_item(16'hA5A5);
    set_shape(16'd300, 16'd40000, 16'd12288, 16'd1);
    send_item(16'hFFFF);
    send_item(16'h8000);
  endtask

  // writes to indexes past the last register change nothing
  task automatic test_unknown_index();
    drain();
    write_reg(8'd4, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    send_item(16'd77);
  endtask

  // random phases: curve sweeps with step 65536/N or a random step, plus scattered indexes
  task automatic test_random();
    int sent;
    int phase_len;
    int n;
    logic [15:0] ex;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 4))
        0: ex = 16'd0;
        1: ex = 16'hFFFF;
        2: ex = 16'($urandom_range(256, 16384));
        default: ex = 16'($urandom);
      endcase
      n = 1 << $urandom_range(0, 9);
      set_shape(($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom),
                ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom), ex,
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(65536 / n));
      phase_len = $urandom_range(40, 110);
      for (int i = 0; i < phase_len && sent < RAND_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) send_item(16'($urandom));
        else send_item(16'(i));
        sent++;
        sender_gap();
        // hold the sender off once until the pipeline has emptied
        if (sent == RAND_ITEMS / 2) drain();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_circle();
    test_extremes();
    test_degenerate();
    test_unknown_index();
    test_random();
    drain();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sep_pkg.sv
sv/sep_sine.sv
sv/sep_log.sv
sv/sep_exp.sv
sv/superellipse_point_generator.sv
verif/superellipse_point_generator_tb.sv
